[sv/pfd_pkg.sv]
package pfd_pkg;

    // Field widths fixed by the port definition.
    localparam int FREQ_W      = 27;
    localparam int TARGET_W    = FREQ_W + 2;
    localparam int N_W         = 4;
    localparam int P_FRAC_BITS = 24;

    // Recommended window for the integer ratio.
    localparam logic [TARGET_W-1:0] N_MIN = TARGET_W'(6);
    localparam logic [TARGET_W-1:0] N_MAX = TARGET_W'(12);

    // Control word that travels alongside each beat through the pipeline.
    typedef struct packed {
        logic valid;
        logic on;
        logic half;
        logic err;
    } t_ctl;

endpackage

[sv/pfd_if.sv]
// Request channel: reference and wanted output frequency.
interface pfd_in_if;
    logic                       valid;
    logic                       ready;
    logic [pfd_pkg::FREQ_W-1:0] ref_freq_hz;
    logic [pfd_pkg::FREQ_W-1:0] out_freq_hz;

    modport source (output valid, output ref_freq_hz, output out_freq_hz, input ready);
    modport sink   (input valid, input ref_freq_hz, input out_freq_hz, output ready);
endinterface

// Result channel: one set of PLL settings per request.
interface pfd_out_if #(
    parameter int K_W = pfd_pkg::P_FRAC_BITS + 1
);
    logic                    valid;
    logic                    ready;
    logic                    pll_on;
    logic                    prescale_half;
    logic [pfd_pkg::N_W-1:0] n_int;
    logic [K_W-1:0]          k_frac;
    logic                    n_warning;
    logic                    div_error;

    modport source (output valid, output pll_on, output prescale_half, output n_int,
                    output k_frac, output n_warning, output div_error, input ready);
    modport sink   (input valid, input pll_on, input prescale_half, input n_int,
                    input k_frac, input n_warning, input div_error, output ready);
endinterface

[sv/pfd_prep.sv]
module pfd_prep #(
    parameter int NQ_W = pfd_pkg::TARGET_W + pfd_pkg::P_FRAC_BITS + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    pfd_in_if.sink                     i_in,
    output pfd_pkg::t_ctl              o_ctl,
    output logic [pfd_pkg::FREQ_W-1:0] o_rem,
    output logic [pfd_pkg::FREQ_W-1:0] o_div,
    output logic [NQ_W-1:0]            o_nq
);
    import pfd_pkg::*;

    logic [TARGET_W-1:0] target;
    logic [TARGET_W:0]   six_ref;
    logic                half;
    logic [FREQ_W-1:0]   div;
    t_ctl                n_ctl;
    t_ctl                r_ctl;
    logic [FREQ_W-1:0]   r_div;
    logic [NQ_W-1:0]     r_nq;

    // The whole pipeline moves together, so the input takes a beat whenever it moves.
    assign i_in.ready = i_en;

    // Target is four times the output. A ratio below the minimum means
    // target < 6 * ref, in which case the reference is halved.
    always_comb begin
        target  = {i_in.out_freq_hz, 2'b00};
        six_ref = {1'b0, i_in.ref_freq_hz, 2'b00} + {2'b00, i_in.ref_freq_hz, 1'b0};
        half    = ({1'b0, target} < six_ref);
        div     = half ? {1'b0, i_in.ref_freq_hz[FREQ_W-1:1]} : i_in.ref_freq_hz;

        n_ctl.valid = i_in.valid;
        n_ctl.on    = (i_in.ref_freq_hz != '0) && (i_in.out_freq_hz != '0);
        n_ctl.half  = half;
        n_ctl.err   = half && (div == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    // Dividend is target followed by the fraction bits plus one rounding bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= div;
            r_nq  <= NQ_W'(target) << (NQ_W - TARGET_W);
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = '0;
    assign o_div = r_div;
    assign o_nq  = r_nq;

endmodule

[sv/pfd_cell.sv]
module pfd_cell #(
    parameter int NQ_W = pfd_pkg::TARGET_W + pfd_pkg::P_FRAC_BITS + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  pfd_pkg::t_ctl              i_ctl,
    input  logic [pfd_pkg::FREQ_W-1:0] i_rem,
    input  logic [pfd_pkg::FREQ_W-1:0] i_div,
    input  logic [NQ_W-1:0]            i_nq,
    output pfd_pkg::t_ctl              o_ctl,
    output logic [pfd_pkg::FREQ_W-1:0] o_rem,
    output logic [pfd_pkg::FREQ_W-1:0] o_div,
    output logic [NQ_W-1:0]            o_nq
);
    import pfd_pkg::*;

    logic [FREQ_W:0]   shifted;
    logic [FREQ_W+1:0] diff;
    logic              ge;
    t_ctl              r_ctl;
    logic [FREQ_W-1:0] r_rem;
    logic [FREQ_W-1:0] r_div;
    logic [NQ_W-1:0]   r_nq;

    // One restoring division step: bring down the next dividend bit, try
    // subtracting the divisor, and shift the quotient bit into the freed slot.
    always_comb begin
        shifted = {i_rem, i_nq[NQ_W-1]};
        diff    = {1'b0, shifted} - {2'b00, i_div};
        ge      = ~diff[FREQ_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
            r_div <= i_div;
            r_nq  <= {i_nq[NQ_W-2:0], ge};
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_nq  = r_nq;

endmodule

[sv/pfd_finish.sv]
module pfd_finish #(
    parameter int FRAC_BITS = pfd_pkg::P_FRAC_BITS,
    parameter int NQ_W      = pfd_pkg::TARGET_W + pfd_pkg::P_FRAC_BITS + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfd_pkg::t_ctl   i_ctl,
    input  logic [NQ_W-1:0] i_nq,
    output logic            o_en,
    pfd_out_if.source       o_out
);
    import pfd_pkg::*;

    logic [TARGET_W-1:0]  ratio;
    logic [FRAC_BITS+1:0] frac_inc;
    logic                 n_on;
    logic                 n_half;
    logic [N_W-1:0]       n_n;
    logic [FRAC_BITS:0]   n_k;
    logic                 n_warn;
    logic                 n_err;
    logic                 r_valid;
    logic                 r_on;
    logic                 r_half;
    logic [N_W-1:0]       r_n;
    logic [FRAC_BITS:0]   r_k;
    logic                 r_warn;
    logic                 r_err;

    // The pipeline advances unless a finished beat is still waiting here.
    assign o_en = ~r_valid | o_out.ready;

    // Quotient holds the integer ratio on top and one extra fraction bit at
    // the bottom; adding one and dropping that bit rounds half up.
    always_comb begin
        ratio    = i_nq[NQ_W-1 -: TARGET_W];
        frac_inc = {1'b0, i_nq[FRAC_BITS:0]} + (FRAC_BITS+2)'(1);

        n_on   = 1'b0;
        n_half = 1'b0;
        n_n    = '0;
        n_k    = '0;
        n_warn = 1'b0;
        n_err  = 1'b0;
        if (i_ctl.on && i_ctl.err) begin
            // Halved reference of zero: no usable ratio.
            n_on   = 1'b1;
            n_half = 1'b1;
            n_warn = 1'b1;
            n_err  = 1'b1;
        end else if (i_ctl.on) begin
            n_on   = 1'b1;
            n_half = i_ctl.half;
            n_n    = ratio[N_W-1:0];
            n_k    = frac_inc[FRAC_BITS+1:1];
            n_warn = (ratio < N_MIN) || (ratio > N_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_on   <= n_on;
            r_half <= n_half;
            r_n    <= n_n;
            r_k    <= n_k;
            r_warn <= n_warn;
            r_err  <= n_err;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.pll_on        = r_on;
    assign o_out.prescale_half = r_half;
    assign o_out.n_int         = r_n;
    assign o_out.k_frac        = r_k;
    assign o_out.n_warning     = r_warn;
    assign o_out.div_error     = r_err;

endmodule

[sv/pll_fractional_divider_calc_top.sv]
// Channel   Port    Direction  Beat contents
// -------   -----   ---------  -----------------------------------------------
// request   i_in    sink       ref_freq_hz, out_freq_hz
// result    o_out   source     pll_on, prescale_half, n_int, k_frac,
//                              n_warning, div_error
//
// A request is taken every cycle while the row moves; its result passes the entry
// register, the row of one-bit restoring division cells and the output register.
// Reset is synchronous and clears all valid bits; nothing else needs clearing.
// A result not taken at the output holds the whole row, and i_in.ready drops
// with it, so no beat is lost; an empty output register never stops the row.
module pll_fractional_divider_calc_top #(
    parameter int FRAC_BITS = pfd_pkg::P_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfd_in_if.sink    i_in,
    pfd_out_if.source o_out
);
    import pfd_pkg::*;

    localparam int NQ_W = TARGET_W + FRAC_BITS + 1;

    logic              en;
    t_ctl              ctl [0:NQ_W];
    logic [FREQ_W-1:0] rem [0:NQ_W];
    logic [FREQ_W-1:0] div [0:NQ_W];
    logic [NQ_W-1:0]   nq  [0:NQ_W];

    // Entry stage: zero checks, prescale decision, dividend setup.
    pfd_prep #(
        .NQ_W (NQ_W)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_in    (i_in),
        .o_ctl   (ctl[0]),
        .o_rem   (rem[0]),
        .o_div   (div[0]),
        .o_nq    (nq[0])
    );

    // One cell per quotient bit: integer ratio first, then the fraction.
    for (genvar g = 0; g < NQ_W; g++) begin : g_cell
        pfd_cell #(
            .NQ_W (NQ_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[g]),
            .i_rem   (rem[g]),
            .i_div   (div[g]),
            .i_nq    (nq[g]),
            .o_ctl   (ctl[g+1]),
            .o_rem   (rem[g+1]),
            .o_div   (div[g+1]),
            .o_nq    (nq[g+1])
        );
    end

    // Rounding, range check and the output register.
    pfd_finish #(
        .FRAC_BITS (FRAC_BITS),
        .NQ_W      (NQ_W)
    ) u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl[NQ_W]),
        .i_nq    (nq[NQ_W]),
        .o_en    (en),
        .o_out   (o_out)
    );

endmodule

[dv/tb_pll_fractional_divider_calc_top.sv]
`timescale 1ns / 100ps

module tb_pll_fractional_divider_calc_top;

    localparam int FREQ_W      = pfd_pkg::FREQ_W;
    localparam int FRAC_BITS   = pfd_pkg::P_FRAC_BITS;
    localparam int K_W         = FRAC_BITS + 1;
    localparam int NUM_DIR     = 20;
    localparam int NUM_RANDOM  = 850;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_TAIL  = FRAC_BITS + 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint unsigned ROUND_SCALE = 10;
    localparam longint unsigned ROUND_HALF  = 5;

    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

    // One set of PLL settings as carried by a result beat.
    typedef struct packed {
        logic           pll_on;
        logic           prescale_half;
        logic [3:0]     n_int;
        logic [K_W-1:0] k_frac;
        logic           n_warning;
        logic           div_error;
    } t_pll_settings;

    // A directed request; fixed rows carry settings typed in by hand.
    typedef struct {
        logic [FREQ_W-1:0] ref_hz;
        logic [FREQ_W-1:0] out_hz;
        bit                fixed;
        t_pll_settings     want;
    } t_dir_row;

    localparam t_pll_settings SET_OFF = '0;
    localparam t_pll_settings SET_DIV_ERR = '{pll_on: 1'b1, prescale_half: 1'b1, n_int: '0,
                                              k_frac: '0, n_warning: 1'b1, div_error: 1'b1};
    localparam t_pll_settings SET_REF1_MAX = '{pll_on: 1'b1, prescale_half: 1'b0,
                                               n_int: 4'd12, k_frac: '0, n_warning: 1'b1,
                                               div_error: 1'b0};

    logic i_clk;
    logic i_rst_n;

    pfd_in_if  req_if ();
    pfd_out_if #(.K_W(K_W)) res_if ();

    pll_fractional_divider_calc_top #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    t_pll_settings pending_settings [$];
    bit            req_take;
    bit            row_fixed;
    t_pll_settings row_want;
    int            send_idle_pct = 33;
    int            stall_pct = 33;
    int            hold_tok = 0;
    int            fail_count = 0;
    int            n_requests = 0;
    int            n_off = 0;
    int            n_div_err = 0;
    int            n_prescale = 0;
    int            n_checked = 0;

    t_dir_row dir_rows [NUM_DIR] = '{
        '{27'd0,        27'd0,        1'b1, SET_OFF},
        '{27'd0,        FREQ_MAX,     1'b1, SET_OFF},
        '{FREQ_MAX,     27'd0,        1'b1, SET_OFF},
        '{27'd1,        27'd1,        1'b1, SET_DIV_ERR},
        '{27'd1,        FREQ_MAX,     1'b1, SET_REF1_MAX},
        '{FREQ_MAX,     FREQ_MAX,     1'b0, SET_OFF},
        '{27'd2,        27'd1,        1'b0, SET_OFF},
        '{27'd3,        27'd1,        1'b0, SET_OFF},
        '{27'd1,        27'd2,        1'b0, SET_OFF},
        '{27'd1000000,  27'd1500000,  1'b0, SET_OFF},
        '{27'd1000000,  27'd3000000,  1'b0, SET_OFF},
        '{27'd1000000,  27'd3250000,  1'b0, SET_OFF},
        '{27'd1000000,  27'd1250000,  1'b0, SET_OFF},
        '{27'd12000000, 27'd24576000, 1'b0, SET_OFF},
        '{27'd27000000, 27'd22579200, 1'b0, SET_OFF},
        '{27'd3,        27'd5,        1'b0, SET_OFF},
        '{27'd1,        27'd4,        1'b0, SET_OFF},
        '{27'h5555555,  27'h2AAAAAA,  1'b0, SET_OFF},
        '{27'h2AAAAAA,  27'h5555555,  1'b0, SET_OFF},
        '{FREQ_MAX,     27'd1,        1'b0, SET_OFF}
    };

    // Works out the PLL settings for one request.
    function automatic t_pll_settings calc_pll_settings(logic [FREQ_W-1:0] ref_hz,
                                                       logic [FREQ_W-1:0] out_hz);
        longint unsigned divisor;
        longint unsigned target;
        longint unsigned ratio;
        longint unsigned rem;
        longint unsigned scaled;
        logic [31:0]     k;
        t_pll_settings   s;
        s = '0;
        if (ref_hz == 0 || out_hz == 0) begin
            return s;
        end
        s.pll_on = 1'b1;
        divisor  = ref_hz;
        target   = 64'(out_hz) * 64'd4;
        ratio    = target / divisor;
        // A low ratio halves the reference; a reference of one halves to nothing.
        if (ratio < pfd_pkg::N_MIN) begin
            divisor         = divisor >> 1;
            s.prescale_half = 1'b1;
            if (divisor == 0) begin
                s.n_warning = 1'b1;
                s.div_error = 1'b1;
                return s;
            end
            ratio = target / divisor;
        end
        s.n_warning = (ratio < pfd_pkg::N_MIN || ratio > pfd_pkg::N_MAX);
        rem    = target % divisor;
        scaled = ((64'd1 << FRAC_BITS) * ROUND_SCALE * rem) / divisor;
        // Rounding happens on a 32-bit word, wide enough that the half-up step cannot wrap.
        k = scaled[31:0];
        if (k % ROUND_SCALE >= ROUND_HALF) begin
            k = k + 32'(ROUND_HALF);
        end
        k = k / 32'(ROUND_SCALE);
        s.n_int  = ratio[3:0];
        s.k_frac = k[K_W-1:0];
        return s;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Offers one request beat and returns at the edge where it is taken.
    task automatic offer_request(logic [FREQ_W-1:0] ref_hz, logic [FREQ_W-1:0] out_hz,
                                 bit fixed, t_pll_settings want);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.ref_freq_hz <= ref_hz;
        req_if.out_freq_hz <= out_hz;
        row_fixed = fixed;
        row_want  = want;
        do @(posedge i_clk); while (!req_take);
    endtask

    // Stops sending and waits until every expected beat has come back.
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_settings.size() != 0);
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Beats are sampled at the falling edge before the rising edge that takes them, when
    // valid, ready and the payload are all stable.
    always @(negedge i_clk) begin
        t_pll_settings want;
        t_pll_settings got;
        req_take = i_rst_n && req_if.valid && req_if.ready;
        if (req_take) begin
            want = row_fixed ? row_want
                             : calc_pll_settings(req_if.ref_freq_hz, req_if.out_freq_hz);
            pending_settings.push_back(want);
            n_requests++;
            n_off      += !want.pll_on;
            n_div_err  += want.div_error;
            n_prescale += want.prescale_half;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{pll_on: res_if.pll_on, prescale_half: res_if.prescale_half,
                    n_int: res_if.n_int, k_frac: res_if.k_frac,
                    n_warning: res_if.n_warning, div_error: res_if.div_error};
            if (pending_settings.size() == 0) begin
                $error("result beat with no request waiting for it");
                fail_count++;
            end else begin
                want = pending_settings.pop_front();
                check_field("pll_on", want.pll_on, got.pll_on);
                check_field("prescale_half", want.prescale_half, got.prescale_half);
                check_field("n_int", want.n_int, got.n_int);
                check_field("k_frac", want.k_frac, got.k_frac);
                check_field("n_warning", want.n_warning, got.n_warning);
                check_field("div_error", want.div_error, got.div_error);
                n_checked++;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_left = 0;
        int hold_seen = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_seen != hold_tok) begin
                hold_seen = hold_tok;
                hold_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_pll_fractional_divider_calc_top NOT OK");
        $finish;
    end

    // Main sequence: reset, directed table, then random requests.
    initial begin
        logic [FREQ_W-1:0] ref_hz;
        logic [FREQ_W-1:0] out_hz;
        longint unsigned   scaled_out;
        int                sel;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.ref_freq_hz <= '0;
        req_if.out_freq_hz <= '0;
        row_fixed = 1'b0;
        row_want  = SET_OFF;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++) begin
            offer_request(dir_rows[i].ref_hz, dir_rows[i].out_hz, dir_rows[i].fixed,
                          dir_rows[i].want);
        end
        wait_for_results();

        for (int i = 0; i < NUM_RANDOM; i++) begin
            // A stretch with no idling on either side, then back to normal.
            if (i == 300) begin
                send_idle_pct = 0;
                stall_pct <= 0;
            end
            if (i == 450) begin
                send_idle_pct = 33;
                stall_pct <= 33;
            end
            // The receiver holds off long enough for the row to fill up.
            if (i == 550) begin
                hold_tok <= hold_tok + 1;
            end
            if (i == 700) begin
                wait_for_results();
            end
            sel = $urandom_range(99);
            if (sel < 10) begin
                // The PLL is turned off by a zero on one side or both.
                ref_hz = ($urandom_range(2) == 0) ? '0 : FREQ_W'($urandom);
                out_hz = (ref_hz != 0 && $urandom_range(1) == 0) ? '0 : FREQ_W'($urandom);
                if (ref_hz != 0) begin
                    out_hz = '0;
                end
            end else if (sel < 20) begin
                // Tiny values reach the halved-reference corner cases.
                ref_hz = FREQ_W'($urandom_range(8, 1));
                out_hz = FREQ_W'($urandom_range(20, 1));
            end else if (sel < 70) begin
                // Realistic setups with ratios spread around the recommended window.
                ref_hz     = FREQ_W'($urandom_range(50000000, 1000000));
                scaled_out = (64'(ref_hz) * $urandom_range(64, 8)) / 16
                             + $urandom_range(ref_hz / 16);
                out_hz     = (scaled_out > FREQ_MAX) ? FREQ_MAX : FREQ_W'(scaled_out);
            end else begin
                ref_hz = FREQ_W'($urandom);
                out_hz = FREQ_W'($urandom);
            end
            offer_request(ref_hz, out_hz, 1'b0, SET_OFF);
        end
        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (pending_settings.size() != 0) begin
            $error("%0d expected results never arrived", pending_settings.size());
            fail_count++;
        end

        $display("Sent %0d requests: %0d with the PLL off, %0d with the reference halved,",
                 n_requests, n_off, n_prescale);
        $display("%0d with a zero halved reference; %0d result beats checked.",
                 n_div_err, n_checked);
        if (fail_count == 0) begin
            $display("tb_pll_fractional_divider_calc_top OK");
        end else begin
            $display("tb_pll_fractional_divider_calc_top NOT OK");
        end
        $finish;
    end

endmodule
